>>> hdl/sppm_radius_flux_update_defines.svh
// assertion macros for the radius and flux update block
`ifndef SPPM_RADIUS_FLUX_UPDATE_DEFINES_SVH
`define SPPM_RADIUS_FLUX_UPDATE_DEFINES_SVH

// condition holds at every edge out of reset
`define SRFU_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define SRFU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/srfu_pkg.sv
// shared types, widths and helpers of the radius and flux update block
package srfu_pkg;

    localparam int W32        = 32;
    localparam int PROD_W     = 48;
    localparam int SUM_W      = 33;
    localparam int NUM_W      = 81;
    localparam int DEN_W      = 49;
    localparam int SPLIT      = 24;
    localparam int PART_W     = 57;
    localparam int FIFO_DEPTH = 4;
    localparam int IN_DATA_W  = 288;
    localparam int OUT_DATA_W = 192;

    localparam logic REG_ALPHA   = 1'b0;
    localparam logic REG_START_K = 1'b1;
    localparam logic [15:0] ALPHA_RESET   = 16'd45875;
    localparam logic [15:0] START_K_RESET = 16'd0;

    typedef struct packed {
        logic          upd;
        logic          cap;
        logic [W32-1:0] total;
        logic [W32-1:0] pass;
        logic [W32-1:0] radius;
        logic [W32-1:0] fx;
        logic [W32-1:0] fy;
        logic [W32-1:0] fz;
    } t_pay;

    typedef struct packed {
        t_pay             pay;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_word;

    function automatic logic [W32-1:0] sat_add32(input logic [W32-1:0] a,
                                                 input logic [W32-1:0] b);
        logic [W32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[W32] ? {W32{1'b1}} : s[W32-1:0];
    endfunction

endpackage

>>> hdl/srfu_front.sv
// front part: classify records and build dividend and divisor
module srfu_front
    import srfu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_alpha,
    input  logic [15:0]          i_start_k,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_surface,
    input  logic [IN_DATA_W-1:0] i_data,
    output logic                 o_push,
    output t_word                o_word,
    input  logic                 i_full
);

    logic [W32-1:0] n_in, m_in, r_in, fx, fy, fz, pfx, pfy, pfz;
    logic upd, cap, en;
    logic [15:0] mul_op;
    logic [SUM_W-1:0] sum;
    t_pay pay;

    logic r_v1, r_v2, r_v3;
    t_pay r_pay1, r_pay2, r_pay3;
    logic [PROD_W-1:0] r_ra1, r_ra2, r_nd1;
    logic [SUM_W-1:0] r_sum1;
    logic [W32-1:0] r_m1;
    logic [PART_W-1:0] r_plo2, r_phi2;
    logic [DEN_W-1:0] r_den2, r_den3;
    logic [NUM_W-1:0] r_num3;

    assign {pfz, pfy, pfx, fz, fy, fx, r_in, m_in, n_in} = i_data;

    assign en      = !r_v3 || !i_full;
    assign o_ready = en;

    always_comb begin
        upd    = i_surface && (m_in != '0);
        cap    = (i_start_k != '0) && (n_in == '0) && (m_in > {16'd0, i_start_k});
        mul_op = cap ? i_start_k : i_alpha;
        sum    = {1'b0, n_in} + {1'b0, m_in};
        pay.upd    = upd;
        pay.cap    = cap;
        pay.radius = r_in;
        if (upd) begin
            pay.total = cap ? {16'd0, i_start_k}
                            : (sum[W32] ? {W32{1'b1}} : sum[W32-1:0]);
            pay.pass  = '0;
            pay.fx    = sat_add32(fx, pfx);
            pay.fy    = sat_add32(fy, pfy);
            pay.fz    = sat_add32(fz, pfz);
        end else begin
            pay.total = n_in;
            pay.pass  = m_in;
            pay.fx    = fx;
            pay.fy    = fy;
            pay.fz    = fz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (en) begin
            r_pay1 <= pay;
            r_ra1  <= r_in * mul_op;
            r_nd1  <= n_in * i_alpha;
            r_sum1 <= sum;
            r_m1   <= m_in;

            r_pay2 <= r_pay1;
            r_ra2  <= r_ra1;
            r_plo2 <= r_ra1[SPLIT-1:0] * r_sum1;
            r_phi2 <= r_ra1[PROD_W-1:SPLIT] * r_sum1;
            r_den2 <= r_pay1.cap ? DEN_W'(r_m1)
                                 : DEN_W'(r_nd1) + DEN_W'({r_m1, 16'd0});

            r_pay3 <= r_pay2;
            r_den3 <= r_den2;
            r_num3 <= r_pay2.cap ? NUM_W'(r_ra2)
                                 : NUM_W'(r_plo2) + NUM_W'({r_phi2, {SPLIT{1'b0}}});
        end
    end

    assign o_push      = r_v3 && !i_full;
    assign o_word.pay  = r_pay3;
    assign o_word.num  = r_num3;
    assign o_word.den  = r_den3;

endmodule

>>> hdl/srfu_fifo.sv
// short queue between front and back parts
`include "sppm_radius_flux_update_defines.svh"
module srfu_fifo
    import srfu_pkg::*;
#(
    parameter int Depth = FIFO_DEPTH
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_word i_word,
    output logic  o_full,
    output logic  o_valid,
    output t_word o_word,
    input  logic  i_pop
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_word r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    `SRFU_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= CntW'(Depth))
    `SRFU_ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `SRFU_ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, r_cnt != '0)

endmodule

>>> hdl/srfu_back.sv
// back part: a load stage, then one quotient bit per stage, then the cap scaling and output register
module srfu_back
    import srfu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_alpha,
    input  logic                  i_valid,
    output logic                  o_pop,
    input  t_word                 i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_updated,
    output logic [OUT_DATA_W-1:0] o_data
);

    localparam int Stages = W32 + 1;

    logic             r_v   [Stages];
    t_pay             r_pay [Stages];
    logic [DEN_W-1:0] r_rem [Stages];
    logic [DEN_W-1:0] r_den [Stages];
    logic [W32-1:0]   r_lq  [Stages];

    logic           r_ov;
    logic           r_oupd;
    logic [OUT_DATA_W-1:0] r_odata;

    logic en;
    logic [W32-1:0] q;
    logic [PROD_W-1:0] qa;
    logic [W32-1:0] rad;
    t_pay lp;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Stages; s++) begin
                r_v[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < Stages; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_ov <= r_v[Stages-1];
        end
        if (en) begin
            r_pay[0] <= i_word.pay;
            r_den[0] <= i_word.den;
            r_rem[0] <= i_word.num[NUM_W-1:W32];
            r_lq[0]  <= i_word.num[W32-1:0];
            for (int s = 1; s < Stages; s++) begin
                logic [DEN_W:0] t;
                logic ge;
                t  = {r_rem[s-1], r_lq[s-1][W32-1]};
                ge = (t >= {1'b0, r_den[s-1]});
                r_rem[s] <= ge ? DEN_W'(t - {1'b0, r_den[s-1]}) : t[DEN_W-1:0];
                r_lq[s]  <= {r_lq[s-1][W32-2:0], ge};
                r_den[s] <= r_den[s-1];
                r_pay[s] <= r_pay[s-1];
            end
            r_oupd  <= lp.upd;
            r_odata <= {lp.fz, lp.fy, lp.fx, rad, lp.pass, lp.total};
        end
    end

    always_comb begin
        lp  = r_pay[Stages-1];
        q   = r_lq[Stages-1];
        qa  = q * i_alpha;
        if (!lp.upd) begin
            rad = lp.radius;
        end else if (lp.cap) begin
            rad = qa[W32+15:16];
        end else begin
            rad = q;
        end
    end

    assign o_valid   = r_ov;
    assign o_updated = r_oupd;
    assign o_data    = r_odata;

endmodule

>>> hdl/sppm_radius_flux_update.sv
// top level of the photon mapping radius and flux update block
// usage:
//   records enter on the s_axis channel: tdata holds the counts, radius and
//   the stored and pass flux, tuser the surface flag. each accepted item gives
//   exactly one item on m_axis: tdata holds the updated fields, tuser the
//   updated flag. alpha and start_k are written over the apb port while idle.
//   an item passes three front stages that build the 81-bit dividend and
//   49-bit divisor, the queue, 33 divider stages (a load stage, then
//   restoring stages producing one quotient bit each), and the output
//   register that also applies the alpha scaling multiply of capped items.
//   throughput is one item per cycle unless m_axis stalls.
//   a four-entry queue decouples the front from the divider pipeline; when
//   m_axis stalls the back part holds, the queue fills, then s_axis_tready
//   drops. reset clears all valid flags and sets the registers to their
//   defaults; no item is lost or repeated under stalls on either side.
module sppm_radius_flux_update
    import srfu_pkg::*;
#(
    parameter int FifoDepth = FIFO_DEPTH
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // total_photons, pass_photons, radius_sq, flux_x, flux_y, flux_z,
    // pass_flux_x, pass_flux_y, pass_flux_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // is_surface
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // new_total_photons, new_pass_photons, new_radius_sq, new_flux_x,
    // new_flux_y, new_flux_z
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // updated
    output logic [0:0]            m_axis_tuser
);

    logic [15:0] r_alpha, r_start_k;
    logic push, full, fvalid, pop;
    t_word fword_in, fword_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= ALPHA_RESET;
            r_start_k <= START_K_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_ALPHA:   r_alpha   <= pwdata[15:0];
                REG_START_K: r_start_k <= pwdata[15:0];
                default:     r_alpha   <= r_alpha;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ALPHA:   prdata = {16'd0, r_alpha};
            REG_START_K: prdata = {16'd0, r_start_k};
            default:     prdata = '0;
        endcase
    end

    srfu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_alpha   (r_alpha),
        .i_start_k (r_start_k),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_surface (s_axis_tuser[0]),
        .i_data    (s_axis_tdata),
        .o_push    (push),
        .o_word    (fword_in),
        .i_full    (full)
    );

    srfu_fifo #(.Depth(FifoDepth)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (fword_in),
        .o_full  (full),
        .o_valid (fvalid),
        .o_word  (fword_out),
        .i_pop   (pop)
    );

    srfu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_alpha   (r_alpha),
        .i_valid   (fvalid),
        .o_pop     (pop),
        .i_word    (fword_out),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_updated (m_axis_tuser[0]),
        .o_data    (m_axis_tdata)
    );

endmodule

>>> tb/sppm_radius_flux_update_tb.sv
// self-checking testbench of the photon mapping radius and flux update block
`timescale 1ns / 1ps

module sppm_radius_flux_update_tb;
    import srfu_pkg::*;

    typedef struct {
        logic        surf;
        logic [31:0] n, m, r, fx, fy, fz, px, py, pz;
    } t_hit;

    typedef struct packed {
        logic        upd;
        logic [31:0] n, m, r, fx, fy, fz;
    } t_upd;

    typedef struct {
        t_hit h;
        bit   known;
        t_upd e;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    logic [15:0] alpha_q = ALPHA_RESET;
    logic [15:0] cap_q = START_K_RESET;
    t_upd pending_updates[$];
    int errors = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    sppm_radius_flux_update dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_upd reduce_radius(t_hit h);
        t_upd o;
        logic [31:0] m;
        logic [63:0] r;
        logic [32:0] s;
        logic [127:0] num, den;
        logic [32:0] t;
        o.upd = 1'b0; o.n = h.n; o.m = h.m; o.r = h.r;
        o.fx = h.fx; o.fy = h.fy; o.fz = h.fz;
        if (!h.surf || h.m == 0) return o;
        m = h.m;
        r = {32'd0, h.r};
        if (cap_q != 0 && h.n == 0 && h.m > cap_q) begin
            r = (r * cap_q) / m;
            m = cap_q;
        end
        s = {1'b0, h.n} + {1'b0, m};
        num = {64'd0, r} * alpha_q * s;
        den = {96'd0, h.n} * alpha_q + ({96'd0, m} << 16);
        o.upd = 1'b1;
        o.n = s[32] ? 32'hFFFF_FFFF : s[31:0];
        o.m = '0;
        o.r = 32'(num / den);
        t = {1'b0, h.fx} + h.px; o.fx = t[32] ? 32'hFFFF_FFFF : t[31:0];
        t = {1'b0, h.fy} + h.py; o.fy = t[32] ? 32'hFFFF_FFFF : t[31:0];
        t = {1'b0, h.fz} + h.pz; o.fz = t[32] ? 32'hFFFF_FFFF : t[31:0];
        return o;
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] a, input logic [15:0] k);
        s_axis_tvalid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
        apb_write({REG_ALPHA, 2'b00}, {16'd0, a});
        apb_write({REG_START_K, 2'b00}, {16'd0, k});
        alpha_q = a;
        cap_q = k;
    endtask

    task automatic send_hit(input t_hit h, input bit known, input t_upd e);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= h.surf;
        s_axis_tdata <= {h.pz, h.py, h.px, h.fz, h.fy, h.fx, h.r, h.m, h.n};
        pending_updates = {pending_updates, (known ? e : reduce_radius(h))};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            3: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_hit rnd_hit();
        t_hit h;
        h.surf = ($urandom_range(0, 7) != 0);
        h.n = ($urandom_range(0, 3) == 0) ? 32'd0 : rnd32();
        h.m = ($urandom_range(0, 9) == 0) ? 32'd0 : rnd32();
        h.r = rnd32();
        h.fx = rnd32(); h.fy = rnd32(); h.fz = rnd32();
        h.px = rnd32(); h.py = rnd32(); h.pz = rnd32();
        return h;
    endfunction

    always @(posedge i_clk) begin
        if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_upd e;
        t_upd a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            a.upd = m_axis_tuser[0];
            {a.fz, a.fy, a.fx, a.r, a.m, a.n} = m_axis_tdata;
            if (pending_updates.size() == 0) begin
                errors++;
                $display("%0t: unexpected item %p", $time, a);
            end else begin
                e = pending_updates.pop_front();
                if (a != e) begin
                    errors++;
                    $display("%0t: expected %p actual %p", $time, e, a);
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row w;
        t_upd none;
        t_hit h;
        none = '{default: '0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        h = '{surf: 0, n: 5, m: 7, r: 32'h10000, fx: 1, fy: 2, fz: 3, px: 4, py: 5, pz: 6};
        w.h = h; w.known = 1; w.e = '{0, 5, 7, 32'h10000, 1, 2, 3}; rows = {rows, w};
        h = '{surf: 1, n: 9, m: 0, r: 32'hFFFF_FFFF, fx: '1, fy: 0, fz: '1, px: '1, py: '1, pz: 0};
        w.h = h; w.e = '{0, 9, 0, 32'hFFFF_FFFF, '1, 0, '1}; rows = {rows, w};
        h = '{surf: 1, n: 0, m: 1, r: 0, fx: '1, fy: '1, fz: '1, px: '1, py: '1, pz: '1};
        w.h = h; w.e = '{1, 1, 0, 0, '1, '1, '1}; rows = {rows, w};
        w.known = 0;
        h = '{surf: 1, n: '1, m: '1, r: '1, fx: 0, fy: 0, fz: 0, px: '1, py: '1, pz: '1};
        w.h = h; rows = {rows, w};
        h = '{surf: 1, n: 100, m: 50, r: 32'h0004_0000, fx: 10, fy: 20, fz: 30, px: 1, py: 2, pz: 3};
        w.h = h; rows = {rows, w};
        h = '{surf: 1, n: 0, m: 1000, r: '1, fx: 0, fy: 0, fz: 0, px: 7, py: 8, pz: 9};
        w.h = h; rows = {rows, w};
        foreach (rows[i]) send_hit(rows[i].h, rows[i].known, rows[i].e);

        set_regs(16'hFFFF, 16'd100);
        foreach (rows[i]) send_hit(rows[i].h, 0, none);
        h = '{surf: 1, n: 0, m: 100, r: '1, fx: 0, fy: 0, fz: 0, px: 0, py: 0, pz: 0};
        send_hit(h, 0, none);
        h.m = 101; send_hit(h, 0, none);
        set_regs(16'd1, 16'hFFFF);
        foreach (rows[i]) send_hit(rows[i].h, 0, none);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_regs(ALPHA_RESET, START_K_RESET);
                1: set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 500)));
                2: set_regs(16'hFFFF, 16'hFFFF);
                default: set_regs(16'($urandom_range(1, 65535)), 16'($urandom));
            endcase
            if (p == 3) calm = 1'b1;
            for (int i = 0; i < 110; i++) begin
                if (p == 1 && i == 50) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_updates.size() != 0) @(posedge i_clk);
                end
                send_hit(rnd_hit(), 0, none);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
        if (errors == 0)
            $display("sppm_radius_flux_update: match");
        else
            $display("sppm_radius_flux_update: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("sppm_radius_flux_update: mismatch");
        $finish;
    end
endmodule

>>> files.f
+incdir+hdl
hdl/srfu_pkg.sv
hdl/srfu_front.sv
hdl/srfu_fifo.sv
hdl/srfu_back.sv
hdl/sppm_radius_flux_update.sv
tb/sppm_radius_flux_update_tb.sv
